@@ hw/rtl/tq_pkg.sv @@
// Package for the team queue: sizes, command and status codes, result type.
// Used by all modules under hw/rtl; depends on nothing.
`timescale 1ns / 1ps
package tq_pkg;
    localparam int ELEMENT_IDS = 1024;
    localparam int TEAMS       = 16;
    localparam int CAPACITY    = 256;
    localparam int EW = $clog2(ELEMENT_IDS);
    localparam int TW = $clog2(TEAMS);
    localparam int NW = $clog2(CAPACITY);

    localparam logic [1:0] CMD_ASSIGN  = 2'd0;
    localparam logic [1:0] CMD_ENQUEUE = 2'd1;
    localparam logic [1:0] CMD_DEQUEUE = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]    status;
        logic [EW-1:0] dequeued;
    } result_t;
endpackage

@@ hw/rtl/team_queue.sv @@
// Team queue: grouped FIFO, one command per transaction, one result each.
// A command is accepted only while the block is idle and its result register
// is empty. On acceptance the membership table and the node store are read;
// in the execute state that follows, the block updates the team registers,
// writes the node store and loads the result register, which drives m_tvalid.
// An enqueue that extends a team writes the old tail's link in a further link
// state, which overlaps the earliest result transaction. The next command can
// thus be accepted only after the previous result has been taken, and later
// whenever the receiver holds off the result. After reset, s_tready stays low
// while a clearing pass empties the membership table.
`timescale 1ns / 1ps
module team_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd [1:0], element [11:2], team [15:12]
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status [1:0], dequeued [11:2], zero [15:12]
    output logic [15:0] m_tdata
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;

    localparam int NC = tq_pkg::NW + 1;
    localparam int HW = tq_pkg::TW;
    localparam int CW = tq_pkg::TW + 1;

    logic [1:0]                state_reg, state_next;
    logic [1:0]                cmd_reg;
    logic [tq_pkg::EW-1:0]     el_reg;
    logic [tq_pkg::NW-1:0]     team_head_reg [tq_pkg::TEAMS];
    logic [tq_pkg::NW-1:0]     team_tail_reg [tq_pkg::TEAMS];
    logic [tq_pkg::TEAMS-1:0]  team_active_reg;
    logic [tq_pkg::TW-1:0]     team_order_reg [tq_pkg::TEAMS];
    logic [tq_pkg::TW-1:0]     order_head_reg;
    logic [tq_pkg::TW:0]       order_count_reg;
    logic [tq_pkg::NW-1:0]     free_head_reg;
    logic [NC-1:0]             free_count_reg;
    logic [NC-1:0]             alloc_next_reg;
    logic [tq_pkg::NW-1:0]     link_addr_reg, link_val_reg;
    logic                      out_valid_reg;
    tq_pkg::result_t           out_reg;

    logic                  accept, mem_rd, mem_valid, mem_busy, nd_wr, nd_val_en;
    logic [tq_pkg::TW-1:0] mem_team, front_team;
    logic [tq_pkg::NW-1:0] nd_addr, nd_rd_addr, nd_link, rd_link, front_node;
    logic [tq_pkg::EW-1:0] rd_value;
    logic [tq_pkg::TW-1:0] order_pos;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg && !mem_busy;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.dequeued, out_reg.status};

    assign front_team = team_order_reg[order_head_reg];
    assign front_node = team_head_reg[front_team];
    assign order_pos  = order_head_reg + order_count_reg[tq_pkg::TW-1:0];

    // Membership lookup on accept; assign writes directly.
    assign mem_rd = accept;
    tq_member u_member (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(accept && s_tdata[1:0] == tq_pkg::CMD_ASSIGN),
        .wr_addr(s_tdata[11:2]), .wr_team(s_tdata[15:12]),
        .rd_en(mem_rd), .rd_addr(s_tdata[11:2]),
        .rd_valid(mem_valid), .rd_team(mem_team), .busy(mem_busy)
    );

    // Node store: on accept, an enqueue reads the free head for its link and
    // any other command reads the front node; writes on execute or link.
    assign nd_rd_addr = (s_tdata[1:0] == tq_pkg::CMD_ENQUEUE) ? free_head_reg : front_node;
    tq_node_store u_nodes (
        .aclk(aclk), .wr_en(nd_wr), .wr_addr(nd_addr), .wr_value(el_reg),
        .wr_link(nd_link), .wr_value_en(nd_val_en),
        .rd_en(accept), .rd_addr(nd_rd_addr),
        .rd_value(rd_value), .rd_link(rd_link)
    );

    logic                  can_enq;
    logic [tq_pkg::NW-1:0] new_node;
    assign can_enq  = (free_count_reg != '0) || (alloc_next_reg < NC'(tq_pkg::CAPACITY));
    assign new_node = (free_count_reg != '0) ? free_head_reg
                                             : alloc_next_reg[tq_pkg::NW-1:0];

    // Node store write selection.
    always_comb begin
        nd_wr     = 1'b0;
        nd_val_en = 1'b0;
        nd_addr   = new_node;
        nd_link   = '0;
        if (state_reg == S_LINK) begin
            nd_wr   = 1'b1;
            nd_addr = link_addr_reg;
            nd_link = link_val_reg;
        end else if (state_reg == S_EXEC) begin
            if (cmd_reg == tq_pkg::CMD_ENQUEUE && mem_valid && can_enq) begin
                nd_wr     = 1'b1;
                nd_val_en = 1'b1;
            end else if (cmd_reg == tq_pkg::CMD_DEQUEUE && order_count_reg != '0) begin
                nd_wr   = 1'b1;
                nd_addr = front_node;
                nd_link = free_head_reg;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_EXEC;
            S_EXEC:  state_next = (cmd_reg == tq_pkg::CMD_ENQUEUE && mem_valid && can_enq
                                   && team_active_reg[mem_team]) ? S_LINK : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Command registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_tdata[1:0];
            el_reg  <= s_tdata[11:2];
        end
    end

    // Queue bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            team_active_reg <= '0;
            order_head_reg  <= '0;
            order_count_reg <= '0;
            free_head_reg   <= '0;
            free_count_reg  <= '0;
            alloc_next_reg  <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < tq_pkg::TEAMS; i++) begin
                team_head_reg[i] <= '0;
                team_tail_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_EXEC) begin
                out_valid_reg <= 1'b1;
                unique case (cmd_reg)
                    tq_pkg::CMD_ASSIGN: begin
                        out_reg.status   <= tq_pkg::ST_OK;
                        out_reg.dequeued <= '0;
                    end
                    tq_pkg::CMD_ENQUEUE: begin
                        out_reg.dequeued <= '0;
                        if (!mem_valid) begin
                            out_reg.status <= tq_pkg::ST_UNKNOWN;
                        end else if (!can_enq) begin
                            out_reg.status <= tq_pkg::ST_FULL;
                        end else begin
                            out_reg.status <= tq_pkg::ST_OK;
                            if (free_count_reg != '0) begin
                                free_head_reg  <= rd_link;
                                free_count_reg <= free_count_reg - NC'(1);
                            end else begin
                                alloc_next_reg <= alloc_next_reg + NC'(1);
                            end
                            team_tail_reg[mem_team] <= new_node;
                            if (team_active_reg[mem_team]) begin
                                link_addr_reg <= team_tail_reg[mem_team];
                                link_val_reg  <= new_node;
                            end else begin
                                team_active_reg[mem_team] <= 1'b1;
                                team_head_reg[mem_team]   <= new_node;
                                team_order_reg[order_pos] <= mem_team;
                                order_count_reg <= order_count_reg + CW'(1);
                            end
                        end
                    end
                    tq_pkg::CMD_DEQUEUE: begin
                        if (order_count_reg == '0) begin
                            out_reg.status   <= tq_pkg::ST_EMPTY;
                            out_reg.dequeued <= '0;
                        end else begin
                            out_reg.status   <= tq_pkg::ST_OK;
                            out_reg.dequeued <= rd_value;
                            if (front_node == team_tail_reg[front_team]) begin
                                team_active_reg[front_team] <= 1'b0;
                                order_head_reg  <= order_head_reg + HW'(1);
                                order_count_reg <= order_count_reg - CW'(1);
                            end else begin
                                team_head_reg[front_team] <= rd_link;
                            end
                            free_head_reg  <= front_node;
                            free_count_reg <= free_count_reg + NC'(1);
                        end
                    end
                    tq_pkg::CMD_CLEAR: begin
                        out_reg.status   <= tq_pkg::ST_OK;
                        out_reg.dequeued <= '0;
                        team_active_reg  <= '0;
                        order_head_reg   <= '0;
                        order_count_reg  <= '0;
                        free_head_reg    <= '0;
                        free_count_reg   <= '0;
                        alloc_next_reg   <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Assertions.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_EXEC)
        else $error("command not executed after acceptance");
    assert property (@(posedge aclk) disable iff (!aresetn)
        order_count_reg <= CW'(tq_pkg::TEAMS))
        else $error("team order ring overfilled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (free_count_reg <= alloc_next_reg))
        else $error("free list larger than allocated nodes");
endmodule

@@ hw/rtl/tq_member.sv @@
// Membership memory: team of each element id, emptied by a clearing pass after reset.
// Depends on tq_pkg.
`timescale 1ns / 1ps
module tq_member (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [tq_pkg::EW-1:0] wr_addr,
    input  logic [tq_pkg::TW-1:0] wr_team,
    input  logic                  rd_en,
    input  logic [tq_pkg::EW-1:0] rd_addr,
    output logic                  rd_valid,
    output logic [tq_pkg::TW-1:0] rd_team,
    output logic                  busy
);
    localparam int AW = tq_pkg::EW;

    // Each entry holds a valid bit above the team number.
    logic [tq_pkg::TW:0]   mem [tq_pkg::ELEMENT_IDS];
    logic [tq_pkg::TW:0]   rd_data_reg;
    logic                  clear_reg;
    logic [tq_pkg::EW-1:0] clear_addr_reg;

    // Clearing pass: one entry per cycle after reset, all ids in turn.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end else if (clear_reg) begin
            clear_addr_reg <= clear_addr_reg + AW'(1);
            if (clear_addr_reg == AW'(tq_pkg::ELEMENT_IDS - 1)) begin
                clear_reg <= 1'b0;
            end
        end
    end

    // Team storage, read through a register.
    always_ff @(posedge aclk) begin
        if (clear_reg) begin
            mem[clear_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= {1'b1, wr_team};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_valid = rd_data_reg[tq_pkg::TW];
    assign rd_team  = rd_data_reg[tq_pkg::TW-1:0];
    assign busy     = clear_reg;
endmodule

@@ hw/rtl/tq_node_store.sv @@
// Node store: element value and link of each queued node, one write port.
// Depends on tq_pkg.
`timescale 1ns / 1ps
module tq_node_store (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [tq_pkg::NW-1:0] wr_addr,
    input  logic [tq_pkg::EW-1:0] wr_value,
    input  logic [tq_pkg::NW-1:0] wr_link,
    input  logic                  wr_value_en,
    input  logic                  rd_en,
    input  logic [tq_pkg::NW-1:0] rd_addr,
    output logic [tq_pkg::EW-1:0] rd_value,
    output logic [tq_pkg::NW-1:0] rd_link
);
    logic [tq_pkg::EW-1:0] value_mem [tq_pkg::CAPACITY];
    logic [tq_pkg::NW-1:0] link_mem  [tq_pkg::CAPACITY];

    // Synchronous read and write; links may be written without the value.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_mem[wr_addr] <= wr_link;
            if (wr_value_en) begin
                value_mem[wr_addr] <= wr_value;
            end
        end
        if (rd_en) begin
            rd_value <= value_mem[rd_addr];
            rd_link  <= link_mem[rd_addr];
        end
    end
endmodule

@@ tb/tq_checker.sv @@
// Checker for the team queue: watches both channels, predicts each result and compares.
// Depends on tq_pkg for sizes and command and status codes.
`timescale 1ns / 1ps
module tq_checker
    import tq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    // Team queue state as the block should hold it.
    logic [4:0]    team_of [ELEMENT_IDS];
    logic [EW-1:0] slot_val [CAPACITY];
    logic [NW-1:0] slot_next [CAPACITY];
    logic [NW-1:0] first_slot [TEAMS];
    logic [NW-1:0] last_slot [TEAMS];
    logic          queued [TEAMS];
    logic [TW-1:0] ring [TEAMS];
    int            ring_front, ring_fill, spare_top, spare_fill, fresh_next;

    result_t       awaited_results[$];

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic void empty_all();
        for (int i = 0; i < TEAMS; i++) begin
            first_slot[i] = '0;
            last_slot[i] = '0;
            queued[i] = 1'b0;
        end
        ring_front = 0;
        ring_fill = 0;
        spare_top = 0;
        spare_fill = 0;
        fresh_next = 0;
    endfunction

    // Works out the result of one command and updates the state.
    function automatic result_t predict_command(input logic [15:0] word);
        logic [1:0]    op;
        logic [EW-1:0] el;
        logic [TW-1:0] tm, t;
        int            n, pos;
        result_t       r;
        op = word[1:0];
        el = word[11:2];
        tm = word[15:12];
        r.status = ST_OK;
        r.dequeued = '0;
        case (op)
            CMD_ASSIGN: begin
                team_of[el] = {1'b0, tm} + 5'd1;
            end
            CMD_ENQUEUE: begin
                if (team_of[el] == 0) begin
                    r.status = ST_UNKNOWN;
                end else begin
                    t = TW'(team_of[el] - 1);
                    if (spare_fill > 0) begin
                        n = spare_top;
                        spare_top = slot_next[n];
                        spare_fill--;
                    end else if (fresh_next < CAPACITY) begin
                        n = fresh_next++;
                    end else begin
                        r.status = ST_FULL;
                    end
                    if (r.status == ST_OK) begin
                        slot_val[n] = el;
                        slot_next[n] = '0;
                        if (queued[t]) begin
                            slot_next[last_slot[t]] = NW'(n);
                            last_slot[t] = NW'(n);
                        end else begin
                            pos = (ring_front + ring_fill) % TEAMS;
                            queued[t] = 1'b1;
                            first_slot[t] = NW'(n);
                            last_slot[t] = NW'(n);
                            ring[pos] = t;
                            ring_fill++;
                        end
                    end
                end
            end
            CMD_DEQUEUE: begin
                if (ring_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    t = ring[ring_front];
                    n = first_slot[t];
                    r.dequeued = slot_val[n];
                    if (NW'(n) == last_slot[t]) begin
                        queued[t] = 1'b0;
                        ring_front = (ring_front + 1) % TEAMS;
                        ring_fill--;
                    end else begin
                        first_slot[t] = slot_next[n];
                    end
                    slot_next[n] = NW'(spare_top);
                    spare_top = n;
                    spare_fill++;
                end
            end
            default: begin
                empty_all();
            end
        endcase
        return r;
    endfunction

    // Predict on each accepted command, compare on each accepted result.
    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < ELEMENT_IDS; i++) team_of[i] = '0;
            empty_all();
            awaited_results.delete();
            fail_count = 0;
        end else begin
            if (s_tvalid && s_tready) awaited_results.push_back(predict_command(s_tdata));
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[1:0];
                got.dequeued = m_tdata[11:2];
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no command outstanding");
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.dequeued !== want.dequeued)
                        report_mismatch($sformatf("dequeued %0d, expected %0d",
                                                  got.dequeued, want.dequeued));
                end
                if (m_tdata[15:12] !== 4'd0) report_mismatch("padding bits not zero");
            end
        end
        pending = awaited_results.size();
    end
endmodule

@@ tb/tb_top.sv @@
// Testbench top for the team queue: clock, reset, command stimulus and verdict.
// Depends on tq_pkg, team_queue and tq_checker.
`timescale 1ns / 1ps
module tb_top;
    import tq_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    int          fail_count, pending;
    int          idle_cycles = 0;
    bit          gaps_on = 1'b1;
    bit          long_hold = 1'b0;
    logic [EW-1:0] crew [$];

    always #5 aclk = ~aclk;

    team_queue DUT (.*);

    tq_checker checker_i (.*);

    // Sends one command and waits for its transaction, at times with a random gap first.
    // The valid stays up until a gap, the next command or a drain takes over.
    task automatic send_command(input logic [1:0] op, input logic [EW-1:0] el,
                                input logic [TW-1:0] tm);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {tm, el, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0 || s_tvalid) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly known members, some never assigned, to reach unknown elements too.
    function automatic logic [EW-1:0] pick_element();
        if (crew.size() > 0 && $urandom_range(0, 9) != 0)
            return crew[$urandom_range(0, crew.size() - 1)];
        return EW'($urandom);
    endfunction

    // Receiver readiness: random stall bursts, one long hold on request.
    initial begin
        int n;
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                long_hold = 1'b0;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 19);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 30);
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int r;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty queue, unknown element, extremes of fields.
        send_command(CMD_DEQUEUE, '0, '0);
        send_command(CMD_ENQUEUE, 10'd1023, 4'd15);
        send_command(CMD_ASSIGN, 10'd0, 4'd0);
        send_command(CMD_ASSIGN, 10'd1023, 4'd15);
        send_command(CMD_ASSIGN, 10'd341, 4'd5);
        send_command(CMD_ASSIGN, 10'd682, 4'd10);
        crew = '{10'd0, 10'd1023, 10'd341, 10'd682};
        send_command(CMD_ENQUEUE, 10'd0, 4'd15);
        send_command(CMD_ENQUEUE, 10'd1023, 4'd0);
        send_command(CMD_ENQUEUE, 10'd0, 4'd0);   // duplicate, joins its team
        send_command(CMD_ENQUEUE, 10'd341, 4'd0);
        send_command(CMD_ASSIGN, 10'd0, 4'd10);   // reassign while queued
        send_command(CMD_ENQUEUE, 10'd0, 4'd0);
        repeat (3) send_command(CMD_DEQUEUE, '0, '0);
        send_command(CMD_CLEAR, 10'd1023, 4'd15);
        send_command(CMD_DEQUEUE, '0, '0);
        send_command(CMD_ENQUEUE, 10'd682, 4'd0);
        send_command(CMD_DEQUEUE, '0, '0);
        send_command(CMD_DEQUEUE, '0, '0);

        // Send more enqueues than the store holds, starting with a long receiver hold.
        long_hold = 1'b1;
        for (int i = 0; i < 270; i++) send_command(CMD_ENQUEUE, pick_element(), '0);
        wait_drained();
        for (int i = 0; i < 40; i++) send_command(CMD_DEQUEUE, '0, '0);
        for (int i = 0; i < 20; i++) send_command(CMD_ENQUEUE, pick_element(), '0);
        send_command(CMD_CLEAR, '0, '0);

        // Random commands, weighted towards enqueue and dequeue.
        for (int i = 0; i < 1100; i++) begin
            if (i == 900) gaps_on = 1'b0;
            if (i == 500) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_command(CMD_ASSIGN, EW'($urandom), TW'($urandom));
                crew.push_back(s_tdata[11:2]);
                if (crew.size() > 40) void'(crew.pop_front());
            end else if (r < 55) begin
                send_command(CMD_ENQUEUE, pick_element(), TW'($urandom));
            end else if (r < 98) begin
                send_command(CMD_DEQUEUE, EW'($urandom), TW'($urandom));
            end else begin
                send_command(CMD_CLEAR, EW'($urandom), TW'($urandom));
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ team_queue.f @@
hw/rtl/tq_pkg.sv
hw/rtl/tq_member.sv
hw/rtl/tq_node_store.sv
hw/rtl/team_queue.sv
tb/tq_checker.sv
tb/tb_top.sv
